>>> rtl/core/tvn_pkg.sv
// ----------------------------------------------------------------------------
// tvn_pkg
// shared widths and pipeline layout of the three-vector normaliser
// ----------------------------------------------------------------------------
package tvn_pkg;

    // component and result widths
    localparam int CW     = 32;   // Q16.16 input component
    localparam int SW     = 64;   // squares and sum of squares
    localparam int QW     = 31;   // result magnitude, up to 2^30
    localparam int ACCW   = 130;  // search accumulators
    localparam int MSHIFT = 62;   // 2^31 squared, scale of the right-hand side

    // pipeline layout
    localparam int N_STEP    = QW;              // one search stage per result bit
    localparam int STG_SRCH0 = 3;               // first search stage
    localparam int STG_OUT   = STG_SRCH0 + N_STEP;
    localparam int N_STG     = STG_OUT + 1;

endpackage

>>> rtl/core/tvn_search.sv
// ----------------------------------------------------------------------------
// tvn_search
// bit-per-stage search for round(mag * 2^30 / sqrt(s)) of one component
// ----------------------------------------------------------------------------
// stage k decides bit (30 - k) of q; u = 2q, P = u*u*s and A = u*s are kept
// so that each test costs shifts and adds only:
//   candidate fits when (u - 1)^2 * s <= mag^2 * 2^62
module tvn_search (
    input  logic                                i_clk,
    input  logic [tvn_pkg::N_STEP-1:0]          i_ld,    // stage load enables
    input  logic [tvn_pkg::SW-1:0]              i_s [tvn_pkg::N_STEP], // s at each stage input
    input  logic [tvn_pkg::SW-1:0]              i_sq,    // mag^2 entering the first stage
    output logic [tvn_pkg::QW-1:0]              o_q
);

    logic [tvn_pkg::QW-1:0]   r_q [tvn_pkg::N_STEP];
    logic [tvn_pkg::ACCW-1:0] r_p [tvn_pkg::N_STEP];
    logic [tvn_pkg::ACCW-1:0] r_a [tvn_pkg::N_STEP];
    logic [tvn_pkg::SW-1:0]   r_m [tvn_pkg::N_STEP];

    for (genvar k = 0; k < tvn_pkg::N_STEP; k++) begin : g_step
        localparam int BIT = tvn_pkg::QW - 1 - k;

        logic [tvn_pkg::QW-1:0]   w_q_in;
        logic [tvn_pkg::ACCW-1:0] w_p_in;
        logic [tvn_pkg::ACCW-1:0] w_a_in;
        logic [tvn_pkg::SW-1:0]   w_m_in;
        logic [tvn_pkg::ACCW-1:0] w_s;
        logic [tvn_pkg::ACCW-1:0] n_p;
        logic [tvn_pkg::ACCW-1:0] n_a;
        logic [tvn_pkg::ACCW-1:0] w_lhs;
        logic [tvn_pkg::ACCW-1:0] w_rhs;
        logic                     w_fit;

        // stage inputs, the first stage starts from q = 0
        if (k == 0) begin : g_first
            assign w_q_in = '0;
            assign w_p_in = '0;
            assign w_a_in = '0;
            assign w_m_in = i_sq;
        end else begin : g_next
            assign w_q_in = r_q[k-1];
            assign w_p_in = r_p[k-1];
            assign w_a_in = r_a[k-1];
            assign w_m_in = r_m[k-1];
        end

        // candidate with this bit set, and the rounding test
        always_comb begin
            w_s   = tvn_pkg::ACCW'(i_s[k]);
            n_p   = w_p_in + (w_a_in << (BIT + 2)) + (w_s << (2 * BIT + 2));
            n_a   = w_a_in + (w_s << (BIT + 1));
            w_lhs = n_p + w_s;
            w_rhs = (tvn_pkg::ACCW'(w_m_in) << tvn_pkg::MSHIFT) + (n_a << 1);
            // once q reaches 2^30 no lower bit may be added
            w_fit = (w_lhs <= w_rhs) && !w_q_in[tvn_pkg::QW-1];
        end

        // stage register
        always_ff @(posedge i_clk) begin
            if (i_ld[k]) begin
                r_m[k] <= w_m_in;
                if (w_fit) begin
                    r_q[k] <= w_q_in | (tvn_pkg::QW'(1) << BIT);
                    r_p[k] <= n_p;
                    r_a[k] <= n_a;
                end else begin
                    r_q[k] <= w_q_in;
                    r_p[k] <= w_p_in;
                    r_a[k] <= w_a_in;
                end
            end
        end
    end

    assign o_q = r_q[tvn_pkg::N_STEP-1];

endmodule

>>> rtl/core/three_vector_normalize.sv
// ----------------------------------------------------------------------------
// three_vector_normalize
// scales a Q16.16 three-component vector to a Q2.30 unit vector
// ----------------------------------------------------------------------------
// Takes one vector per clock and returns one unit vector per clock unless the
// output stalls, each component rounded to nearest with ties away from zero;
// an all-zero vector gives zero components and raises the zero_vector flag in
// tuser. The pipeline holds one input register, the squaring multipliers, the
// sum of squares, 31 search stages that each settle one result bit, and the
// output register. Every stage has its own valid bit and moves on whenever the
// stage after it is free, so bubbles close up and back-pressure loses nothing.
module three_vector_normalize (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // x_in, y_in, z_in
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // x_unit, y_unit, z_unit
    output logic        m_axis_tuser    // zero_vector
);

    localparam int NC = 3;

    logic [tvn_pkg::N_STG-1:0] r_v;
    logic [tvn_pkg::N_STG:0]   w_rdy;

    logic [tvn_pkg::CW-1:0] r_mag [NC];
    logic [tvn_pkg::SW-1:0] r_sq  [NC];
    logic [tvn_pkg::SW-1:0] r_sq2 [NC];
    logic [NC-1:0]          r_neg [tvn_pkg::STG_OUT];
    logic [tvn_pkg::SW-1:0] r_s   [tvn_pkg::STG_OUT];
    logic                   r_zero[tvn_pkg::STG_OUT];
    logic [tvn_pkg::QW-1:0] w_q   [NC];
    logic [tvn_pkg::SW-1:0] w_s_step [tvn_pkg::N_STEP];
    logic [tvn_pkg::N_STEP-1:0] w_ld;
    logic [95:0]            r_out;
    logic                   r_zv;

    // ready ripples back: a stage takes a beat when empty or draining
    assign w_rdy[tvn_pkg::N_STG] = m_axis_tready;
    for (genvar i = 0; i < tvn_pkg::N_STG; i++) begin : g_rdy
        assign w_rdy[i] = !r_v[i] || w_rdy[i+1];
    end
    assign s_axis_tready = w_rdy[0];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < tvn_pkg::N_STG; i++) begin
                if (w_rdy[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    // front end: magnitudes, squares, sum of squares, then side data
    // running alongside the search stages
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NC; c++) begin
            if (w_rdy[0]) begin
                r_neg[0][c] <= s_axis_tdata[c*tvn_pkg::CW + tvn_pkg::CW - 1];
                r_mag[c]    <= s_axis_tdata[c*tvn_pkg::CW + tvn_pkg::CW - 1]
                             ? (tvn_pkg::CW'(0) - s_axis_tdata[c*tvn_pkg::CW +: tvn_pkg::CW])
                             : s_axis_tdata[c*tvn_pkg::CW +: tvn_pkg::CW];
            end
            if (w_rdy[1]) begin
                r_sq[c] <= tvn_pkg::SW'(r_mag[c]) * tvn_pkg::SW'(r_mag[c]);
            end
            if (w_rdy[2]) begin
                r_sq2[c] <= r_sq[c];
            end
        end
        if (w_rdy[1]) begin
            r_neg[1] <= r_neg[0];
        end
        if (w_rdy[2]) begin
            r_neg[2]  <= r_neg[1];
            r_s[2]    <= r_sq[0] + r_sq[1] + r_sq[2];
            r_zero[2] <= (r_sq[0] == '0) && (r_sq[1] == '0) && (r_sq[2] == '0);
        end
        for (int i = tvn_pkg::STG_SRCH0; i < tvn_pkg::STG_OUT; i++) begin
            if (w_rdy[i]) begin
                r_neg[i]  <= r_neg[i-1];
                r_s[i]    <= r_s[i-1];
                r_zero[i] <= r_zero[i-1];
            end
        end
    end

    // search stage k reads s from the register in front of it
    for (genvar k = 0; k < tvn_pkg::N_STEP; k++) begin : g_sstep
        assign w_s_step[k] = r_s[tvn_pkg::STG_SRCH0 - 1 + k];
        assign w_ld[k]     = w_rdy[tvn_pkg::STG_SRCH0 + k];
    end

    for (genvar c = 0; c < NC; c++) begin : g_comp
        tvn_search u_search (
            .i_clk (i_clk),
            .i_ld  (w_ld),
            .i_s   (w_s_step),
            .i_sq  (r_sq2[c]),
            .o_q   (w_q[c])
        );
    end

    // output register: sign and zero-vector handling
    always_ff @(posedge i_clk) begin
        if (w_rdy[tvn_pkg::STG_OUT]) begin
            r_zv <= r_zero[tvn_pkg::STG_OUT-1];
            for (int c = 0; c < NC; c++) begin
                if (r_zero[tvn_pkg::STG_OUT-1]) begin
                    r_out[c*tvn_pkg::CW +: tvn_pkg::CW] <= '0;
                end else if (r_neg[tvn_pkg::STG_OUT-1][c]) begin
                    r_out[c*tvn_pkg::CW +: tvn_pkg::CW] <= tvn_pkg::CW'(0) - {1'b0, w_q[c]};
                end else begin
                    r_out[c*tvn_pkg::CW +: tvn_pkg::CW] <= {1'b0, w_q[c]};
                end
            end
        end
    end

    assign m_axis_tvalid = r_v[tvn_pkg::STG_OUT];
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_zv;

    // an empty output stage means the whole pipe can take a beat
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output stage");

    // a zero vector leaves with zero components
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("zero vector with non-zero components");

    // a beat in the sum stage reaches the first search stage unless stalled
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[2] && w_rdy[3]) |=> r_v[3])
        else $error("beat lost entering the search stages");

    // the two lower unit components (bits 63:0) do not exceed one in magnitude
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (($signed(m_axis_tdata[31:0])  <= 32'sd1073741824)
                        && ($signed(m_axis_tdata[31:0])  >= -32'sd1073741824)
                        && ($signed(m_axis_tdata[63:32]) <= 32'sd1073741824)
                        && ($signed(m_axis_tdata[63:32]) >= -32'sd1073741824)))
        else $error("unit component out of range");

endmodule
